// ===== rtl/polyline_segment_intersect_scan_defines.svh =====
// Assertion macros used by the checker file.
`ifndef POLYLINE_SEGMENT_INTERSECT_SCAN_DEFINES_SVH
`define POLYLINE_SEGMENT_INTERSECT_SCAN_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psis_pkg.sv =====
// Shared types, codes and helpers of the polyline segment intersection scanner.
`default_nettype none

package psis_pkg;

  // command codes on kind_i
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;

  // stored vertex word: y in the upper half, x in the lower half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  // per-segment tag travelling down the test pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } seg_ctl_t;

  // 0 <= n/d <= 1 for nonzero d, without a divide
  function automatic logic unit_ratio(input logic signed [CROSS_W-1:0] n,
                                      input logic signed [CROSS_W-1:0] d);
    logic r;
    if (d > 0) begin
      r = (n >= 0) && (n <= d);
    end else begin
      r = (n <= 0) && (n >= d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/psis_vstore.sv =====
// Vertex memory: one write port, one read port, registered read data.
`default_nettype none

module psis_vstore import psis_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  vertex_t       wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output vertex_t       rdata_o
);

  vertex_t mem_q [DEPTH];
  vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/psis_meet.sv =====
// Four-stage segment intersection test: diffs, products, crosses, decision.
`default_nettype none

module psis_meet import psis_pkg::*; #(
  parameter int IW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flush_i,
  input  seg_ctl_t      in_ctl_i,
  input  logic [IW-1:0] in_idx_i,
  input  vertex_t       p_i,
  input  vertex_t       p2_i,
  input  vertex_t       q_i,
  input  vertex_t       q2_i,
  output seg_ctl_t      out_ctl_o,
  output logic [IW-1:0] out_idx_o,
  output logic          hit_o
);

  logic signed [COORD_W-1:0] px, py, p2x, p2y, qx, qy, q2x, q2y;
  logic signed [DIFF_W-1:0]  rx_d, ry_d, sx_d, sy_d, dx_d, dy_d;
  logic signed [DIFF_W-1:0]  cx0, cx1, cx2, cx3, cy0, cy1, cy2, cy3;
  logic                      col_d;

  // stage 1
  seg_ctl_t                  s1_ctl_q;
  logic [IW-1:0]             s1_idx_q;
  logic signed [DIFF_W-1:0]  rx_q, ry_q, sx_q, sy_q, dx_q, dy_q;
  logic                      s1_col_q;
  // stage 2
  seg_ctl_t                  s2_ctl_q;
  logic [IW-1:0]             s2_idx_q;
  logic signed [PROD_W-1:0]  dxry_q, dyrx_q, rxsy_q, rysx_q, dxsy_q, dysx_q;
  logic                      s2_col_q;
  // stage 3
  seg_ctl_t                  s3_ctl_q;
  logic [IW-1:0]             s3_idx_q;
  logic signed [CROSS_W-1:0] un_q, den_q, tn_q;
  logic                      s3_col_q;
  // stage 4
  seg_ctl_t                  s4_ctl_q;
  logic [IW-1:0]             s4_idx_q;
  logic                      s4_hit_q;
  logic                      hit_d;

  assign px  = p_i.x;
  assign py  = p_i.y;
  assign p2x = p2_i.x;
  assign p2y = p2_i.y;
  assign qx  = q_i.x;
  assign qy  = q_i.y;
  assign q2x = q2_i.x;
  assign q2y = q2_i.y;

  assign rx_d = DIFF_W'(p2x) - DIFF_W'(px);
  assign ry_d = DIFF_W'(p2y) - DIFF_W'(py);
  assign sx_d = DIFF_W'(q2x) - DIFF_W'(qx);
  assign sy_d = DIFF_W'(q2y) - DIFF_W'(qy);
  assign dx_d = DIFF_W'(qx)  - DIFF_W'(px);
  assign dy_d = DIFF_W'(qy)  - DIFF_W'(py);

  // collinear overlap: parity of endpoint sign tests per axis
  assign cx0 = DIFF_W'(qx)  - DIFF_W'(px);
  assign cx1 = DIFF_W'(qx)  - DIFF_W'(p2x);
  assign cx2 = DIFF_W'(q2x) - DIFF_W'(px);
  assign cx3 = DIFF_W'(q2x) - DIFF_W'(p2x);
  assign cy0 = DIFF_W'(qy)  - DIFF_W'(py);
  assign cy1 = DIFF_W'(qy)  - DIFF_W'(p2y);
  assign cy2 = DIFF_W'(q2y) - DIFF_W'(py);
  assign cy3 = DIFF_W'(q2y) - DIFF_W'(p2y);
  assign col_d = (cx0[DIFF_W-1] ^ cx1[DIFF_W-1] ^ cx2[DIFF_W-1] ^ cx3[DIFF_W-1]) |
                 (cy0[DIFF_W-1] ^ cy1[DIFF_W-1] ^ cy2[DIFF_W-1] ^ cy3[DIFF_W-1]);

  always_comb begin
    if ((un_q == '0) && (den_q == '0)) begin
      hit_d = s3_col_q;
    end else if (den_q == '0) begin
      hit_d = 1'b0;
    end else begin
      hit_d = unit_ratio(tn_q, den_q) && unit_ratio(un_q, den_q);
    end
  end

  // tag valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
    end else if (flush_i) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
      s4_ctl_q <= '0;
    end else begin
      s1_ctl_q <= in_ctl_i;
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
      s4_ctl_q <= s3_ctl_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    s1_idx_q <= in_idx_i;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    s1_col_q <= col_d;

    s2_idx_q <= s1_idx_q;
    dxry_q   <= dx_q * ry_q;
    dyrx_q   <= dy_q * rx_q;
    rxsy_q   <= rx_q * sy_q;
    rysx_q   <= ry_q * sx_q;
    dxsy_q   <= dx_q * sy_q;
    dysx_q   <= dy_q * sx_q;
    s2_col_q <= s1_col_q;

    s3_idx_q <= s2_idx_q;
    un_q     <= CROSS_W'(dxry_q) - CROSS_W'(dyrx_q);
    den_q    <= CROSS_W'(rxsy_q) - CROSS_W'(rysx_q);
    tn_q     <= CROSS_W'(dxsy_q) - CROSS_W'(dysx_q);
    s3_col_q <= s2_col_q;

    s4_idx_q <= s3_idx_q;
    s4_hit_q <= hit_d;
  end

  assign out_ctl_o = s4_ctl_q;
  assign out_idx_o = s4_idx_q;
  assign hit_o     = s4_hit_q;

endmodule

`default_nettype wire

// ===== rtl/polyline_segment_intersect_scan.sv =====
// Top level: polyline vertex store and first-hit segment intersection scan.
//
//  channel   direction  handshake               words
//  command   in         start & !busy           kind_i, first_*_i, second_*_i
//  result    out        done_o strobe, 1 cycle  hit_o, segment_index_o
//
// Clear and append take effect at the accept edge; they produce no result and
// never raise busy. A query on fewer than three vertices answers a miss in the
// cycle after accept. Otherwise the scan reads one vertex a cycle from the
// single-read-port store and streams segments through a four-stage test
// pipeline: a hit reports the end vertex of the first hitting segment, a miss
// comes after the last segment. busy stays high for the whole scan.
// Reset clears the vertex count and control; the store itself is not cleared.
// The receiver cannot stall: each result word shows for exactly one cycle.
`default_nettype none

module polyline_segment_intersect_scan import psis_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind_i,
  input  logic signed [COORD_W-1:0] first_x_i,
  input  logic signed [COORD_W-1:0] first_y_i,
  input  logic signed [COORD_W-1:0] second_x_i,
  input  logic signed [COORD_W-1:0] second_y_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic [7:0]                segment_index_o
);

  localparam int AW = $clog2(MAX_POINTS);      // store address
  localparam int CW = $clog2(MAX_POINTS + 1);  // vertex count, holds MAX_POINTS

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] count_q, count_d;

  // read issue side
  logic          issue_q, issue_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] last_q, last_d;
  // read return side
  logic          rv_q, rv_d;
  logic [AW-1:0] ridx_q;
  vertex_t       prev_q;
  vertex_t       rdata;

  // query endpoints, held for the scan
  vertex_t       p_q, p2_q;

  // result word
  logic          done_q, done_d;
  logic          hit_q, hit_d;
  logic [7:0]    sidx_q, sidx_d;

  logic          accept;
  logic          is_query, short_query;
  logic          wr_en;

  seg_ctl_t      seg_ctl;
  seg_ctl_t      res_ctl;
  logic [AW-1:0] res_idx;
  logic          res_hit;
  logic          finish;
  logic [AW+7:0] res_idx_ext;

  assign accept      = start && !busy;
  assign is_query    = accept && (kind_i == KIND_QUERY);
  assign short_query = count_q < CW'(3);
  assign wr_en       = accept && (kind_i == KIND_APPEND) && (count_q < CW'(MAX_POINTS));

  // segments start at end vertex 2; vertex 1 only primes prev_q
  assign seg_ctl.valid = rv_q && (ridx_q != AW'(1));
  assign seg_ctl.last  = ridx_q == last_q;

  // first hit wins; pipeline order keeps earlier segments ahead
  assign finish      = res_ctl.valid && (res_hit || res_ctl.last);
  assign res_idx_ext = {8'b0, res_idx};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    issue_d = issue_q;
    rd_d    = rd_q;
    last_d  = last_q;
    rv_d    = issue_q;
    done_d  = 1'b0;
    hit_d   = 1'b0;
    sidx_d  = '0;

    if (accept) begin
      case (kind_i)
        KIND_CLEAR: begin
          count_d = '0;
        end
        KIND_APPEND: begin
          if (wr_en) begin
            count_d = count_q + CW'(1);
          end
        end
        KIND_QUERY: begin
          if (short_query) begin
            done_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
            issue_d = 1'b1;
            rd_d    = AW'(1);
            last_d  = AW'(count_q - CW'(1));
          end
        end
        default: begin
        end
      endcase
    end

    if (issue_q) begin
      if (rd_q == last_q) begin
        issue_d = 1'b0;
      end else begin
        rd_d = rd_q + AW'(1);
      end
    end

    if (finish) begin
      state_d = ST_IDLE;
      issue_d = 1'b0;
      rv_d    = 1'b0;
      done_d  = 1'b1;
      hit_d   = res_hit;
      sidx_d  = res_hit ? res_idx_ext[7:0] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      issue_q <= 1'b0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q   <= rd_d;
    last_q <= last_d;
    ridx_q <= rd_q;
    hit_q  <= hit_d;
    sidx_q <= sidx_d;
    if (rv_q) begin
      prev_q <= rdata;
    end
    if (is_query) begin
      p_q  <= '{y: first_y_i, x: first_x_i};
      p2_q <= '{y: second_y_i, x: second_x_i};
    end
  end

  // Appends only land while idle and reads only run during a scan, so a
  // read never meets a write to the same entry.
  psis_vstore #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ('{y: first_y_i, x: first_x_i}),
    .re_i    (issue_q),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  psis_meet #(
    .IW (AW)
  ) u_meet (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .flush_i   (finish),
    .in_ctl_i  (seg_ctl),
    .in_idx_i  (ridx_q),
    .p_i       (p_q),
    .p2_i      (p2_q),
    .q_i       (prev_q),
    .q2_i      (rdata),
    .out_ctl_o (res_ctl),
    .out_idx_o (res_idx),
    .hit_o     (res_hit)
  );

  assign busy            = state_q == ST_SCAN;
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign segment_index_o = sidx_q;

endmodule

`default_nettype wire

// ===== rtl/psis_checker.sv =====
// Port-level checks on the scanner, bound to the top level.
`default_nettype none
`include "polyline_segment_intersect_scan_defines.svh"

module psis_checker import psis_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] kind_i,
  input wire logic       done_o,
  input wire logic       hit_o,
  input wire logic [7:0] segment_index_o
);

  `PSIS_ASSERT_IMP(a_miss_index_zero, done_o && !hit_o, segment_index_o == 8'd0, "miss with nonzero index")
  `PSIS_ASSERT_IMP(a_scan_ends_with_word, $fell(busy), done_o, "scan ended without a result word")
  `PSIS_ASSERT_IMP(a_scan_from_query, $rose(busy), $past(start) && $past(kind_i) == KIND_QUERY, "scan started without a query")
  `PSIS_ASSERT_NXT(a_no_word_for_edit, start && !busy && kind_i != KIND_QUERY, !done_o, "result word after a non-query command")

endmodule

bind polyline_segment_intersect_scan psis_checker u_psis_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .kind_i          (kind_i),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .segment_index_o (segment_index_o)
);

`default_nettype wire

// ===== verif/tb_polyline_segment_intersect_scan.sv =====
// Testbench for the polyline segment intersection scanner: directed table plus random episodes.
`timescale 1ns / 1ps

module tb_polyline_segment_intersect_scan;
  import psis_pkg::*;

  localparam int POLY_MAX    = 256;
  localparam int ITEM_GOAL   = 1850;       // accepted words, directed rows included
  localparam int TAIL_CYCLES = 300;        // long enough to outlast the longest scan
  localparam longint CYCLE_LIMIT = 2_500_000;

  // kind 3 has no name in the package; the block accepts it and does nothing
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // how coordinates of one episode are spread
  localparam int COORD_GRID  = 0;          // few values, lots of collinear/parallel cases
  localparam int COORD_LOCAL = 1;          // cluster around a center
  localparam int COORD_WIDE  = 2;          // whole signed 16-bit range

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t CMIN = 16'sh8000;
  localparam coord_t CMAX = 16'sh7FFF;

  typedef struct packed {
    logic       hit;
    logic [7:0] seg_idx;
  } answer_t;

  // one command word; known marks a row whose answer is typed in by hand
  typedef struct packed {
    logic [1:0] kind;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by;
    logic       known;
    answer_t    ans;
  } plan_row_t;

  localparam answer_t MISS = '{1'b0, 8'd0};

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [1:0]   kind_i = KIND_CLEAR;
  coord_t       first_x_i = '0;
  coord_t       first_y_i = '0;
  coord_t       second_x_i = '0;
  coord_t       second_y_i = '0;
  logic         done_o;
  logic         hit_o;
  logic [7:0]   segment_index_o;

  // predictor state: mirror of the stored polyline
  vertex_t      poly_pts [POLY_MAX];
  int           poly_len = 0;

  answer_t      pending_answers [$];   // answers owed by the block, oldest first
  plan_row_t    plan [$];              // directed table
  int           words_sent = 0;        // words accepted by the block
  int           errors = 0;
  bit           steady = 1'b0;         // no gaps on the command side while set
  longint       cycle_count = 0;

  always #5 clk_i = ~clk_i;

  polyline_segment_intersect_scan #(
    .MAX_POINTS(POLY_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .segment_index_o(segment_index_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor: exact integer segment test, first hit along the polyline.
  // ---------------------------------------------------------------------------

  function automatic longint wedge(input longint ax, ay, bx, by);
    return ax * by - ay * bx;
  endfunction

  // n/d within [0,1] with d nonzero, no divide
  function automatic bit in_unit(input longint n, d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction

  // query p..e against stored q..f
  function automatic bit segments_meet(input longint px, py, ex, ey, qx, qy, fx, fy);
    longint rx, ry, sx, sy, dx, dy, un, den, tn;
    bit     xs, ys;
    rx  = ex - px;
    ry  = ey - py;
    sx  = fx - qx;
    sy  = fy - qy;
    dx  = qx - px;
    dy  = qy - py;
    un  = wedge(dx, dy, rx, ry);
    den = wedge(rx, ry, sx, sy);
    if (un == 0 && den == 0) begin
      // collinear: parity of the endpoint orderings, per axis
      xs = (qx < px) ^ (qx < ex) ^ (fx < px) ^ (fx < ex);
      ys = (qy < py) ^ (qy < ey) ^ (fy < py) ^ (fy < ey);
      return xs | ys;
    end
    if (den == 0) return 1'b0;   // parallel, never a hit
    tn = wedge(dx, dy, sx, sy);
    return in_unit(tn, den) && in_unit(un, den);
  endfunction

  // scan segments (i-1,i) from i = 2; short polylines fall straight through
  function automatic answer_t first_crossing(input coord_t ax, ay, bx, by);
    answer_t a;
    a = MISS;
    for (int i = 2; i < poly_len && i < POLY_MAX; i++) begin
      if (segments_meet(ax, ay, bx, by, poly_pts[i-1].x, poly_pts[i-1].y,
                        poly_pts[i].x, poly_pts[i].y)) begin
        a.hit     = 1'b1;
        a.seg_idx = 8'(i);
        return a;
      end
    end
    return a;
  endfunction

  // apply an accepted word; returns 1 if the word had any effect
  function automatic bit track_word(input plan_row_t w);
    case (w.kind)
      KIND_CLEAR: begin
        poly_len = 0;
        return 1'b1;
      end
      KIND_APPEND: begin
        if (poly_len >= POLY_MAX) return 1'b0;   // store full, append dropped
        poly_pts[poly_len].x = w.ax;
        poly_pts[poly_len].y = w.ay;
        poly_len++;
        return 1'b1;
      end
      KIND_QUERY: begin
        pending_answers.insert(pending_answers.size(),
                               w.known ? w.ans : first_crossing(w.ax, w.ay, w.bx, w.by));
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  function automatic coord_t pick(input int mode, ctr, span);
    int v;
    case (mode)
      COORD_GRID:  v = int'($urandom_range(0, 4)) * span - 2 * span;
      COORD_LOCAL: v = ctr + int'($urandom_range(0, 2 * span)) - span;
      default:     v = int'($urandom() & 32'hFFFF) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // word with every coordinate random over the whole range
  function automatic plan_row_t wild(input logic [1:0] k);
    plan_row_t w;
    w.kind  = k;
    w.ax    = pick(COORD_WIDE, 0, 0);
    w.ay    = pick(COORD_WIDE, 0, 0);
    w.bx    = pick(COORD_WIDE, 0, 0);
    w.by    = pick(COORD_WIDE, 0, 0);
    w.known = 1'b0;
    w.ans   = MISS;
    return w;
  endfunction

  // append one row to the directed table
  function automatic void put_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // present one word, hold it until start & !busy at an edge, then maybe idle
  task automatic issue(input plan_row_t w);
    int n;
    start      <= 1'b1;
    kind_i     <= w.kind;
    first_x_i  <= w.ax;
    first_y_i  <= w.ay;
    second_x_i <= w.bx;
    second_y_i <= w.by;
    do @(posedge clk_i); while (busy);
    void'(track_word(w));
    words_sent++;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // hold off with start low until every owed answer is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // occasional kind 3 word slipped in between real commands
  task automatic stray();
    if ($urandom_range(0, 24) == 0) issue(wild(KIND_SPARE));
  endtask

  // one episode: usually clear, build a polyline, then fire queries at it
  task automatic run_episode(input bit fill_up);
    int        mode, ctr, span, n_pts, n_q, r, k, j;
    plan_row_t w;
    vertex_t   v;
    steady = ($urandom_range(0, 3) == 0);
    r      = $urandom_range(0, 9);
    mode   = (r < 3) ? COORD_GRID : (r < 9) ? COORD_LOCAL : COORD_WIDE;
    ctr    = (mode == COORD_LOCAL) ? int'($urandom_range(0, 40000)) - 20000 : 0;
    span   = (mode == COORD_GRID) ? (1 << (4 * $urandom_range(0, 2)))
                                  : (1 << $urandom_range(3, 13));
    // polyline length: mostly short (0..2 exercises the short-polyline miss)
    r = $urandom_range(0, 19);
    if (fill_up) n_pts = POLY_MAX + $urandom_range(1, 6);
    else if (r < 14) n_pts = $urandom_range(0, 12);
    else if (r < 19) n_pts = $urandom_range(13, 64);
    else n_pts = $urandom_range(200, POLY_MAX + 4);

    if (fill_up || $urandom_range(0, 4) != 0) issue(wild(KIND_CLEAR));
    for (k = 0; k < n_pts && words_sent < ITEM_GOAL; k++) begin
      stray();
      w    = wild(KIND_APPEND);
      w.ax = pick(mode, ctr, span);
      w.ay = pick(mode, ctr, span);
      issue(w);
    end

    n_q = $urandom_range(1, (poly_len > 64) ? 6 : 10);
    for (k = 0; k < n_q && words_sent < ITEM_GOAL; k++) begin
      stray();
      w = wild(KIND_QUERY);
      r = $urandom_range(0, 9);
      if (r < 6 || poly_len == 0) begin
        w.ax = pick(mode, ctr, span);
        w.ay = pick(mode, ctr, span);
        w.bx = pick(mode, ctr, span);
        w.by = pick(mode, ctr, span);
      end else if (r < 8 || poly_len < 2) begin
        // start on a stored vertex: touching cases
        v    = poly_pts[$urandom_range(0, poly_len - 1)];
        w.ax = v.x;
        w.ay = v.y;
        w.bx = pick(mode, ctr, span);
        w.by = pick(mode, ctr, span);
      end else if (r < 9) begin
        // exact copy of a stored segment, either direction: collinear path
        j = $urandom_range(1, poly_len - 1);
        if ($urandom_range(0, 1)) begin
          w.ax = poly_pts[j-1].x; w.ay = poly_pts[j-1].y;
          w.bx = poly_pts[j].x;   w.by = poly_pts[j].y;
        end else begin
          w.ax = poly_pts[j].x;   w.ay = poly_pts[j].y;
          w.bx = poly_pts[j-1].x; w.by = poly_pts[j-1].y;
        end
      end
      // otherwise keep the wide random query
      issue(w);
    end
    if ($urandom_range(0, 7) == 0) drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: done_o is a one-cycle strobe, no back-pressure possible
  // ---------------------------------------------------------------------------

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("result word with nothing owed: hit=%0b index=%0d",
                             hit_o, segment_index_o));
      end else begin
        want = pending_answers.pop_front();
        if (hit_o !== want.hit)
          flag_error($sformatf("hit mismatch: expected %0b, got %0b (index exp %0d got %0d)",
                               want.hit, hit_o, want.seg_idx, segment_index_o));
        else if (segment_index_o !== want.seg_idx)
          flag_error($sformatf("index mismatch: expected %0d, got %0d (hit %0b)",
                               want.seg_idx, segment_index_o, hit_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[polyline_segment_intersect_scan] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int settle;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table: kind, first x/y, second x/y, answer typed in?, answer
    put_row('{KIND_QUERY,  CMIN, CMIN, CMAX, CMAX, 1'b1, MISS});          // empty
    put_row('{KIND_SPARE,  CMAX, CMIN, CMAX, CMIN, 1'b0, MISS});          // no effect
    put_row('{KIND_APPEND, CMIN, CMIN, CMAX, CMAX, 1'b0, MISS});
    put_row('{KIND_APPEND, CMAX, CMAX, CMIN, CMIN, 1'b0, MISS});
    put_row('{KIND_QUERY,  CMIN, CMIN, CMAX, CMAX, 1'b1, MISS});          // 2 vertices
    put_row('{KIND_APPEND, CMAX, CMIN, 16'sd0, 16'sd0, 1'b0, MISS});
    // horizontal line ending on the right-edge vertical segment
    put_row('{KIND_QUERY,  CMIN, 16'sd0, CMAX, 16'sd0, 1'b1, '{1'b1, 8'd2}});
    put_row('{KIND_QUERY,  CMIN, CMIN, CMAX, CMAX, 1'b0, MISS});          // hits a vertex
    put_row('{KIND_QUERY,  16'sd0, 16'sd0, 16'sd16, 16'sd16, 1'b0, MISS});
    put_row('{KIND_QUERY,  CMAX, CMAX, CMIN, CMIN, 1'b0, MISS});
    put_row('{KIND_CLEAR,  CMAX, CMAX, CMAX, CMAX, 1'b0, MISS});
    put_row('{KIND_QUERY,  16'sd0, 16'sd16, 16'sd0, 16'sd16, 1'b1, MISS}); // cleared
    put_row('{KIND_APPEND, 16'sd0, 16'sd0, CMIN, CMAX, 1'b0, MISS});
    put_row('{KIND_APPEND, 16'sd16, 16'sd0, CMIN, CMAX, 1'b0, MISS});
    put_row('{KIND_APPEND, 16'sd32, 16'sd0, CMIN, CMAX, 1'b0, MISS});
    put_row('{KIND_APPEND, 16'sd32, 16'sd32, CMIN, CMAX, 1'b0, MISS});
    put_row('{KIND_QUERY,  16'sd8, 16'sd0, 16'sd24, 16'sd0, 1'b0, MISS});  // collinear, overlap
    put_row('{KIND_QUERY,  16'sd40, 16'sd0, 16'sd50, 16'sd0, 1'b0, MISS}); // collinear, apart
    put_row('{KIND_QUERY,  16'sd0, 16'sd16, 16'sd16, 16'sd16, 1'b0, MISS}); // parallel
    put_row('{KIND_QUERY,  16'sd32, 16'sd40, 16'sd32, 16'sd8, 1'b0, MISS}); // vertical overlap
    put_row('{KIND_QUERY,  16'sd24, -16'sd8, 16'sd24, 16'sd8, 1'b0, MISS}); // plain crossing
    put_row('{KIND_QUERY,  16'sd32, 16'sd0, 16'sd32, 16'sd0, 1'b0, MISS});  // point query
    put_row('{KIND_SPARE,  CMIN, CMAX, CMIN, CMAX, 1'b0, MISS});
    put_row('{KIND_QUERY,  CMAX, CMAX, CMIN, CMIN, 1'b0, MISS});
    put_row('{KIND_CLEAR,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, MISS});

    foreach (plan[i]) issue(plan[i]);
    drain();                      // hold off until the block is quiet once

    run_episode(1'b1);            // fill the store and push appends past full
    while (words_sent < ITEM_GOAL) run_episode(1'b0);

    // let the last answers arrive, then watch a while for strays
    start  <= 1'b0;
    settle = 0;
    while (pending_answers.size() != 0 && settle < 5000) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0)
      flag_error($sformatf("%0d answers never arrived", pending_answers.size()));

    if (errors == 0) begin
      $display("[polyline_segment_intersect_scan] OK");
    end else begin
      $display("[polyline_segment_intersect_scan] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/psis_pkg.sv
rtl/psis_vstore.sv
rtl/psis_meet.sv
rtl/polyline_segment_intersect_scan.sv
rtl/psis_checker.sv
verif/tb_polyline_segment_intersect_scan.sv
